// File: sv/rcsrq_pkg.sv
`timescale 1ns / 1ps

package rcsrq_pkg;

    // Event codes carried in the command field.
    typedef enum logic [2:0] {
        CMD_SRQ        = 3'd0,
        CMD_STATUS     = 3'd1,
        CMD_STATUS_EXT = 3'd2,
        CMD_ALL_PAIRS  = 3'd3,
        CMD_TIME       = 3'd4,
        CMD_ERROR      = 3'd5,
        CMD_STOP       = 3'd6,
        CMD_CUTOUT     = 3'd7
    } t_cmd;

    // Service-request phase.
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_PENDING    = 2'd1,
        PH_RESPONDING = 2'd2
    } t_phase;

    // Channel-2 datagram identifiers.
    localparam logic [2:0] ID_ALL_PAIRS = 3'd3;
    localparam logic [2:0] ID_STATUS    = 3'd4;
    localparam logic [2:0] ID_TIME      = 3'd5;
    localparam logic [2:0] ID_ERROR     = 3'd6;

    // Channel codes.
    localparam logic CH_SRQ  = 1'b0;
    localparam logic CH_RESP = 1'b1;

    // Byte counts.
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    // Input word.
    typedef struct packed {
        t_cmd        command;
        logic [10:0] address;
        logic        ext_format;
        logic [7:0]  value;
        logic        match_flag;
        logic        setpoint_flag;
        logic        one_second_res;
        logic        more_error_data;
    } t_in;

    // Result word.
    typedef struct packed {
        logic       channel;
        logic [3:0] header_nibble;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] byte_count;
    } t_out;

    // Result of one processed event, handed from the core to the output stage.
    typedef struct packed {
        logic valid;
        t_out word;
    } t_core_res;

endpackage

// File: sv/rcsrq_core.sv
`timescale 1ns / 1ps

module rcsrq_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rcsrq_pkg::t_in     i_item,
    output rcsrq_pkg::t_core_res o_res
);
    import rcsrq_pkg::*;

    t_phase      r_phase, n_phase;
    logic [10:0] r_addr, n_addr;
    logic        r_ext, n_ext;
    logic [2:0]  r_resp_id, n_resp_id;
    logic [7:0]  r_resp_b0, n_resp_b0;
    logic [7:0]  r_resp_b1, n_resp_b1;
    logic [1:0]  r_resp_count, n_resp_count;
    logic        r_resp_valid, n_resp_valid;
    logic [7:0]  status_byte;
    logic        is_report;

    assign status_byte = {1'b0, i_item.setpoint_flag, i_item.match_flag, i_item.value[4:0]};
    assign is_report = (i_item.command == CMD_STATUS) || (i_item.command == CMD_STATUS_EXT) ||
                       (i_item.command == CMD_ALL_PAIRS) || (i_item.command == CMD_TIME) ||
                       (i_item.command == CMD_ERROR);

    // Next phase of the service request.
    always_comb begin
        n_phase = r_phase;
        case (i_item.command)
            CMD_SRQ: begin
                n_phase = PH_PENDING;
            end
            CMD_STOP: begin
                if (r_phase == PH_PENDING) begin
                    n_phase = PH_RESPONDING;
                end
            end
            CMD_CUTOUT: begin
                if (r_phase == PH_RESPONDING) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    // Stored address and queued response; a report replaces any earlier one.
    always_comb begin
        n_addr       = r_addr;
        n_ext        = r_ext;
        n_resp_id    = r_resp_id;
        n_resp_b0    = r_resp_b0;
        n_resp_b1    = r_resp_b1;
        n_resp_count = r_resp_count;
        n_resp_valid = r_resp_valid;
        case (i_item.command)
            CMD_SRQ: begin
                n_addr = i_item.address;
                n_ext  = i_item.ext_format;
            end
            CMD_STATUS: begin
                n_resp_id    = ID_STATUS;
                n_resp_b0    = status_byte;
                n_resp_count = CNT_ONE;
                n_resp_valid = 1'b1;
            end
            CMD_STATUS_EXT: begin
                n_resp_id    = ID_STATUS;
                n_resp_b0    = status_byte;
                n_resp_b1    = {5'd0, i_item.value[7:5]};
                n_resp_count = CNT_TWO;
                n_resp_valid = 1'b1;
            end
            CMD_ALL_PAIRS: begin
                n_resp_id    = ID_ALL_PAIRS;
                n_resp_b0    = i_item.value;
                n_resp_count = CNT_ONE;
                n_resp_valid = 1'b1;
            end
            CMD_TIME: begin
                n_resp_id    = ID_TIME;
                n_resp_b0    = {i_item.one_second_res, i_item.value[6:0]};
                n_resp_count = CNT_ONE;
                n_resp_valid = 1'b1;
            end
            CMD_ERROR: begin
                n_resp_id    = ID_ERROR;
                n_resp_b0    = {1'b0, i_item.more_error_data, i_item.value[5:0]};
                n_resp_count = CNT_ONE;
                n_resp_valid = 1'b1;
            end
            CMD_CUTOUT: begin
                if (r_phase == PH_RESPONDING) begin
                    n_resp_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Result of a cutout: the SRQ datagram while pending, the queued response while
    // responding.
    always_comb begin
        o_res = '0;
        if (i_item.command == CMD_CUTOUT) begin
            case (r_phase)
                PH_PENDING: begin
                    o_res.valid              = 1'b1;
                    o_res.word.channel       = CH_SRQ;
                    o_res.word.header_nibble = {r_ext, r_addr[10:8]};
                    o_res.word.first_byte    = r_addr[7:0];
                    o_res.word.second_byte   = 8'd0;
                    o_res.word.byte_count    = CNT_ONE;
                end
                PH_RESPONDING: begin
                    o_res.valid              = r_resp_valid;
                    o_res.word.channel       = CH_RESP;
                    o_res.word.header_nibble = {1'b0, r_resp_id};
                    o_res.word.first_byte    = r_resp_b0;
                    o_res.word.second_byte   = (r_resp_count == CNT_TWO) ? r_resp_b1 : 8'd0;
                    o_res.word.byte_count    = r_resp_count;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_addr       <= '0;
            r_ext        <= 1'b0;
            r_resp_id    <= '0;
            r_resp_count <= '0;
            r_resp_valid <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_addr       <= n_addr;
            r_ext        <= n_ext;
            r_resp_id    <= n_resp_id;
            r_resp_count <= n_resp_count;
            r_resp_valid <= n_resp_valid;
        end
    end

    // Response bytes have no reset; they are read only after a report writes them.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_resp_b0 <= n_resp_b0;
            r_resp_b1 <= n_resp_b1;
        end
    end

    // A cutout while pending leaves the request pending.
    a_cutout_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.command == CMD_CUTOUT) && (r_phase == PH_PENDING)
        |=> r_phase == PH_PENDING)
        else $error("cutout while pending changed the phase");

    // A cutout while responding drains the queue and returns to idle.
    a_cutout_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.command == CMD_CUTOUT) && (r_phase == PH_RESPONDING)
        |=> (r_phase == PH_IDLE) && !r_resp_valid)
        else $error("cutout while responding did not clear the response");

    // Every report leaves a valid response queued.
    a_report_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && is_report |=> r_resp_valid && (r_resp_count != 2'd0))
        else $error("report did not queue a response");

endmodule

// File: sv/rcsrq_out_reg.sv
`timescale 1ns / 1ps

module rcsrq_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  rcsrq_pkg::t_core_res i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rcsrq_pkg::t_out      o_result
);
    import rcsrq_pkg::*;

    logic r_valid;
    t_out r_word;

    // The register can take a new word when empty or when its word leaves now.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_word;

    // Valid flag of the held word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Held word.
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_word <= i_res.word;
        end
    end

endmodule

// File: sv/railcom_accessory_srq_responder_unit.sv
`timescale 1ns / 1ps
// A result word shows on o_valid after its event passes the input and output registers.
// Throughput: one event per cycle while the receiver keeps up. A word held in the output
// register stalls the registered event; an empty input register takes one more event and
// then o_ready stays low until that word is taken.
// Reset (synchronous, active low) sets the phase to idle, clears the stored address,
// the queued-response flag and both valid flags.

module railcom_accessory_srq_responder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rcsrq_pkg::t_in  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output rcsrq_pkg::t_out o_result
);
    import rcsrq_pkg::*;

    logic      r_in_valid;
    t_in       r_in;
    logic      out_free;
    logic      advance;
    t_core_res core_res;

    // The registered event is processed once the output register can take its result.
    assign advance = r_in_valid && out_free;
    assign o_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    rcsrq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    rcsrq_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_res    (core_res),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule
